### rtl/core/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// shared widths, controller states and command/status types for the
// modular exponentiation core
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int BASE_W = 63;
	localparam int EXP_W  = 63;
	localparam int MOD_W  = 32;
	localparam int CNT_MAX = (BASE_W > MOD_W) ? BASE_W : MOD_W;
	localparam int CNT_W  = $clog2(CNT_MAX);

	localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(64'd1000000007);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQ_INIT,
		ST_CHECK,
		ST_MUL_ACC,
		ST_WR_ACC,
		ST_MUL_SQ,
		ST_WR_SQ,
		ST_FINISH
	} mexp_state_t;

	typedef struct packed {
		logic load;
		logic red_step;
		logic sq_write;
		logic mul_load;
		logic mul_sel_acc;
		logic mul_step;
		logic acc_write;
		logic exp_shift;
		logic out_load;
	} mexp_cmd_t;

	typedef struct packed {
		logic exp_zero;
		logic exp_lsb;
		logic mod_zero;
	} mexp_stat_t;

endpackage

### rtl/core/mexp_dp.sv
// ----------------------------------------------------------------------------
// mexp_dp
// datapath: modulus register, bit-serial base reduction, shared bit-serial
// modular multiplier, running result and square, result register
// ----------------------------------------------------------------------------
module mexp_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     modulus_we,
	input  logic [mexp_pkg::MOD_W-1:0]  modulus_wdata,
	input  logic [mexp_pkg::BASE_W-1:0] base,
	input  logic [mexp_pkg::EXP_W-1:0]  exponent,
	input  mexp_pkg::mexp_cmd_t      cmd,
	output mexp_pkg::mexp_stat_t     stat,
	output logic [mexp_pkg::MOD_W-1:0]  power_residue
);
	import mexp_pkg::*;

	logic [MOD_W-1:0]  mod_q;
	logic [BASE_W-1:0] base_q;
	logic [EXP_W-1:0]  exp_q;
	logic [MOD_W-1:0]  acc_q;
	logic [MOD_W-1:0]  sq_q;
	logic [MOD_W-1:0]  r_q;
	logic [MOD_W-1:0]  a_q;
	logic [MOD_W-1:0]  b_q;
	logic [MOD_W-1:0]  res_q;

	logic [MOD_W:0] mod_ext;
	logic [MOD_W:0] red_sum;
	logic [MOD_W-1:0] red_next;
	logic [MOD_W:0] dbl;
	logic [MOD_W-1:0] dbl_red;
	logic [MOD_W:0] add_sum;
	logic [MOD_W-1:0] mul_next;

	assign mod_ext = {1'b0, mod_q};

	// reduction: shift in one base bit
	always_comb begin
		red_sum  = {r_q, base_q[BASE_W-1]};
		red_next = (red_sum >= mod_ext) ? MOD_W'(red_sum - mod_ext) : red_sum[MOD_W-1:0];
	end

	// multiplier: double, then add a when the multiplier bit is set
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= mod_ext) ? MOD_W'(dbl - mod_ext) : dbl[MOD_W-1:0];
		add_sum = {1'b0, dbl_red} + (b_q[MOD_W-1] ? {1'b0, a_q} : {(MOD_W+1){1'b0}});
		mul_next = (add_sum >= mod_ext) ? MOD_W'(add_sum - mod_ext) : add_sum[MOD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RESET;
		end else if (modulus_we) begin
			mod_q <= modulus_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base;
			exp_q  <= exponent;
			r_q    <= '0;
			acc_q  <= (mod_q == MOD_W'(1)) ? '0 : MOD_W'(1);
		end else begin
			if (cmd.red_step) begin
				base_q <= {base_q[BASE_W-2:0], 1'b0};
				r_q    <= red_next;
			end
			if (cmd.mul_load) begin
				r_q <= '0;
				a_q <= sq_q;
				b_q <= cmd.mul_sel_acc ? acc_q : sq_q;
			end
			if (cmd.mul_step) begin
				r_q <= mul_next;
				b_q <= {b_q[MOD_W-2:0], 1'b0};
			end
			if (cmd.acc_write) begin
				acc_q <= r_q;
			end
			if (cmd.sq_write) begin
				sq_q <= r_q;
			end
			if (cmd.exp_shift) begin
				exp_q <= {1'b0, exp_q[EXP_W-1:1]};
			end
		end
		if (cmd.out_load) begin
			res_q <= (mod_q == '0) ? '0 : acc_q;
		end
	end

	assign stat.exp_zero = (exp_q == '0);
	assign stat.exp_lsb  = exp_q[0];
	assign stat.mod_zero = (mod_q == '0);
	assign power_residue = res_q;

endmodule

### rtl/core/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// controller: sequences reduction, square-and-multiply over exponent bits,
// and the handoff to the result register
// ----------------------------------------------------------------------------
module mexp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  mexp_pkg::mexp_stat_t stat,
	output mexp_pkg::mexp_cmd_t  cmd
);
	import mexp_pkg::*;

	mexp_state_t state_q;
	mexp_state_t state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic slot_free;
	logic red_last;
	logic mul_last;

	assign slot_free = !out_valid_q || !out_stall;
	assign red_last  = (cnt_q == CNT_W'(BASE_W - 1));
	assign mul_last  = (cnt_q == CNT_W'(MOD_W - 1));
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = stat.mod_zero ? ST_FINISH : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (red_last) begin
					state_nx = ST_SQ_INIT;
				end
			end
			ST_SQ_INIT: state_nx = ST_CHECK;
			ST_CHECK: begin
				if (stat.exp_zero) begin
					state_nx = ST_FINISH;
				end else if (stat.exp_lsb) begin
					state_nx = ST_MUL_ACC;
				end else begin
					state_nx = ST_MUL_SQ;
				end
			end
			ST_MUL_ACC: begin
				if (mul_last) begin
					state_nx = ST_WR_ACC;
				end
			end
			ST_WR_ACC: state_nx = ST_MUL_SQ;
			ST_MUL_SQ: begin
				if (mul_last) begin
					state_nx = ST_WR_SQ;
				end
			end
			ST_WR_SQ: state_nx = ST_CHECK;
			ST_FINISH: begin
				if (slot_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:    cmd.load = in_valid;
			ST_REDUCE:  cmd.red_step = 1'b1;
			ST_SQ_INIT: cmd.sq_write = 1'b1;
			ST_CHECK: begin
				if (!stat.exp_zero) begin
					cmd.mul_load    = 1'b1;
					cmd.mul_sel_acc = stat.exp_lsb;
				end
			end
			ST_MUL_ACC: cmd.mul_step = 1'b1;
			ST_WR_ACC: begin
				cmd.acc_write = 1'b1;
				cmd.mul_load  = 1'b1;
			end
			ST_MUL_SQ:  cmd.mul_step = 1'b1;
			ST_WR_SQ: begin
				cmd.sq_write  = 1'b1;
				cmd.exp_shift = 1'b1;
			end
			ST_FINISH:  cmd.out_load = slot_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load || cmd.mul_load) begin
				cnt_q <= '0;
			end else if (cmd.red_step || cmd.mul_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> slot_free)
		else $error("result loaded over a pending beat");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result dropped");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> (state_q != ST_IDLE))
		else $error("accepted beat not started");
	a_red_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REDUCE) |-> (cnt_q < CNT_W'(BASE_W)))
		else $error("reduction counter overrun");
`endif

endmodule

### rtl/core/modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// base^exponent mod modulus by right-to-left square-and-multiply
//
//   channel  signals                         dir
//   in       in_valid/in_stall, base, exponent   input beat
//   out      out_valid/out_stall, power_residue  result beat
//   cfg      modulus_we, modulus_wdata           modulus write
//
// one item at a time: bit-serial base reduction, then per exponent bit up
// to the highest set one, a square plus a multiply when the bit is set,
// both on the shared bit-serial modular multiplier
// modulus resets to 1000000007; zero modulus skips the reduction and gives 0
// a waiting result does not block the next input beat
// ----------------------------------------------------------------------------
module modular_exponentiation_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      modulus_we,
	input  logic [mexp_pkg::MOD_W-1:0]  modulus_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [mexp_pkg::BASE_W-1:0] base,
	input  logic [mexp_pkg::EXP_W-1:0]  exponent,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [mexp_pkg::MOD_W-1:0]  power_residue
);
	import mexp_pkg::*;

	mexp_cmd_t  cmd;
	mexp_stat_t stat;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mexp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.modulus_we    (modulus_we),
		.modulus_wdata (modulus_wdata),
		.base          (base),
		.exponent      (exponent),
		.cmd           (cmd),
		.stat          (stat),
		.power_residue (power_residue)
	);

endmodule
